// ===== hw/rtl/pixel_format_to_rgba8_top_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef PIXEL_FORMAT_TO_RGBA8_TOP_ASSERT_SVH
`define PIXEL_FORMAT_TO_RGBA8_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PF2R_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel format assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PF2R_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel format assertion failed");

`endif

// ===== hw/rtl/pf2r_pkg.sv =====
`default_nettype none
package pf2r_pkg;

  localparam logic [2:0] FMT_RGBA8     = 3'd0;
  localparam logic [2:0] FMT_BGRA8     = 3'd1;
  localparam logic [2:0] FMT_HALF      = 3'd2;
  localparam logic [2:0] FMT_RGB10A2   = 3'd3;
  localparam logic [2:0] FMT_R11G11B10 = 3'd4;

  localparam int NumChan = 4;
  localparam int ChanW   = 8;
  localparam int FmtW    = 3;
  localparam int SigW    = 11;
  localparam int ShiftW  = 5;
  localparam int ProdW   = SigW + ChanW;

  typedef enum logic [1:0] {
    MODE_CONST = 2'd0,
    MODE_FLOAT = 2'd1,
    MODE_UNORM = 2'd2
  } chan_mode_t;

  // Work left for one channel after decode.
  typedef struct packed {
    chan_mode_t          mode;
    logic [ChanW-1:0]    value;
    logic [SigW-1:0]     sig;
    logic [ShiftW-1:0]   shift;
  } chan_op_t;

  // Same channel after the multiply by 255.
  typedef struct packed {
    chan_mode_t          mode;
    logic [ChanW-1:0]    value;
    logic [ProdW-1:0]    prod;
    logic [ShiftW-1:0]   shift;
  } chan_prod_t;

  // Per-pixel flags that ride along the pipeline.
  typedef struct packed {
    logic unsupported;
    logic last;
  } pix_side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pf2r_decode.sv =====
`default_nettype none
module pf2r_decode (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [pf2r_pkg::FmtW-1:0]           pixel_format,
  input  wire logic [63:0]                         raw_pixel,
  input  wire logic                                last_in,
  output pf2r_pkg::chan_op_t [pf2r_pkg::NumChan-1:0] ops,
  output pf2r_pkg::pix_side_t                      side
);
  import pf2r_pkg::*;

  localparam logic [4:0]        ExpMax    = 5'd31;
  localparam logic [4:0]        ExpOne    = 5'd15;
  localparam logic [ShiftW-1:0] ShiftBase = 5'd25;
  localparam logic [ShiftW-1:0] ShiftDen  = 5'd24;

  chan_op_t [NumChan-1:0] ops_next;
  pix_side_t              side_next;
  logic [31:0]            w;

  function automatic chan_op_t const_op(input logic [ChanW-1:0] v);
    chan_op_t op;
    op.mode  = MODE_CONST;
    op.value = v;
    op.sig   = '0;
    op.shift = '0;
    return op;
  endfunction

  function automatic chan_op_t unorm_op(input logic [9:0] v);
    chan_op_t op;
    op.mode  = MODE_UNORM;
    op.value = '0;
    op.sig   = {1'b0, v};
    op.shift = '0;
    return op;
  endfunction

  // Unsigned float, 5-bit exponent with bias 15, mantissa left-aligned to 10 bits.
  // The result is floor(x*255) = (sig*255) >> (25 - e) for values below one.
  function automatic chan_op_t ufloat_op(input logic [4:0] e, input logic [9:0] m);
    chan_op_t op;
    op = const_op('0);
    if (e == ExpMax) begin
      op.value = (m != '0) ? 8'd0 : 8'hFF;
    end else if (e >= ExpOne) begin
      op.value = 8'hFF;
    end else if (e == '0) begin
      op.mode  = MODE_FLOAT;
      op.sig   = {1'b0, m};
      op.shift = ShiftDen;
    end else begin
      op.mode  = MODE_FLOAT;
      op.sig   = {1'b1, m};
      op.shift = ShiftBase - e;
    end
    return op;
  endfunction

  // Any negative half, including NaN with the sign set, gives zero.
  function automatic chan_op_t half_op(input logic [15:0] h);
    chan_op_t op;
    if (h[15]) begin
      op = const_op('0);
    end else begin
      op = ufloat_op(h[14:10], h[9:0]);
    end
    return op;
  endfunction

  assign w = raw_pixel[31:0];

  always_comb begin
    side_next.unsupported = 1'b0;
    side_next.last        = last_in;
    ops_next              = '0;
    case (pixel_format)
      FMT_RGBA8: begin
        ops_next[0] = const_op(w[7:0]);
        ops_next[1] = const_op(w[15:8]);
        ops_next[2] = const_op(w[23:16]);
        ops_next[3] = const_op(w[31:24]);
      end
      FMT_BGRA8: begin
        ops_next[0] = const_op(w[23:16]);
        ops_next[1] = const_op(w[15:8]);
        ops_next[2] = const_op(w[7:0]);
        ops_next[3] = const_op(w[31:24]);
      end
      FMT_HALF: begin
        ops_next[0] = half_op(raw_pixel[15:0]);
        ops_next[1] = half_op(raw_pixel[31:16]);
        ops_next[2] = half_op(raw_pixel[47:32]);
        ops_next[3] = half_op(raw_pixel[63:48]);
      end
      FMT_RGB10A2: begin
        ops_next[0] = unorm_op(w[9:0]);
        ops_next[1] = unorm_op(w[19:10]);
        ops_next[2] = unorm_op(w[29:20]);
        // a*85 for a two-bit alpha is the pair repeated four times.
        ops_next[3] = const_op({w[31:30], w[31:30], w[31:30], w[31:30]});
      end
      FMT_R11G11B10: begin
        ops_next[0] = ufloat_op(w[10:6], {w[5:0], 4'b0});
        ops_next[1] = ufloat_op(w[21:17], {w[16:11], 4'b0});
        ops_next[2] = ufloat_op(w[31:27], {w[26:22], 5'b0});
        ops_next[3] = const_op(8'hFF);
      end
      default: begin
        side_next.unsupported = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops  <= ops_next;
      side <= side_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pf2r_mult.sv =====
`default_nettype none
module pf2r_mult (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire pf2r_pkg::chan_op_t    op,
  output pf2r_pkg::chan_prod_t       prod
);
  import pf2r_pkg::*;

  chan_prod_t prod_next;

  always_comb begin
    prod_next.mode  = op.mode;
    prod_next.value = op.value;
    prod_next.shift = op.shift;
    // sig*255 as sig*256 - sig.
    prod_next.prod  = {op.sig, {ChanW{1'b0}}} - {{ChanW{1'b0}}, op.sig};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pf2r_finish.sv =====
`default_nettype none
module pf2r_finish (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire pf2r_pkg::chan_prod_t        prod,
  output logic [pf2r_pkg::ChanW-1:0]       chan
);
  import pf2r_pkg::*;

  localparam int QW = ProdW - 10;
  localparam logic [10:0] Den = 11'd1023;

  logic [ChanW-1:0] chan_next;
  logic [ProdW-1:0] shifted;
  logic [QW-1:0]    q0;
  logic [10:0]      rem;
  logic [QW-1:0]    quot;

  // Division by 1023: x>>10 is low by at most one, and the remainder
  // x - 1023*q0 reduces to the low ten bits plus q0.
  assign q0      = prod.prod[ProdW-1:10];
  assign rem     = {1'b0, prod.prod[9:0]} + {{(11-QW){1'b0}}, q0};
  assign quot    = q0 + {{(QW-1){1'b0}}, (rem >= Den)};
  assign shifted = prod.prod >> prod.shift;

  always_comb begin
    case (prod.mode)
      MODE_FLOAT: chan_next = shifted[ChanW-1:0];
      MODE_UNORM: chan_next = quot[ChanW-1:0];
      default:    chan_next = prod.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan <= chan_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pixel_format_to_rgba8_top.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_stall   raw_pixel, last_in
// out      out_valid / out_stall red, green, blue, alpha, unsupported, last_out
// cfg      cfg_wr_en             cfg_wr_data (pixel format)
//
// Three register stages: decode, multiply by 255, shift or divide by 1023.
// One pixel per cycle while out_stall lets the pipeline move.
// The rate is set by the single-entry registers of each stage.
// rst is synchronous and clears the valid bits and the format register.
// A stage takes a new request whenever it is empty or its content moves on,
// so out_stall holds the whole pipeline without dropping or repeating data.
`default_nettype none
module pixel_format_to_rgba8_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pf2r_pkg::FmtW-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [63:0]                   raw_pixel,
  input  wire logic                          last_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pf2r_pkg::ChanW-1:0]         red,
  output logic [pf2r_pkg::ChanW-1:0]         green,
  output logic [pf2r_pkg::ChanW-1:0]         blue,
  output logic [pf2r_pkg::ChanW-1:0]         alpha,
  output logic                               unsupported,
  output logic                               last_out
);
  import pf2r_pkg::*;

  logic [FmtW-1:0]        pixel_format;
  logic                   valid1;
  logic                   valid2;
  logic                   en1;
  logic                   en2;
  logic                   en3;
  chan_op_t [NumChan-1:0] ops;
  pix_side_t              side1;
  pix_side_t              side2;
  chan_prod_t [NumChan-1:0] prods;
  logic [NumChan-1:0][ChanW-1:0] chans;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !valid2 || en3;
  assign en1      = !valid1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGBA8;
    end else if (cfg_wr_en) begin
      pixel_format <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        valid1 <= in_valid;
      end
      if (en2) begin
        valid2 <= valid1;
      end
      if (en3) begin
        out_valid <= valid2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      side2 <= side1;
    end
    if (en3) begin
      unsupported <= side2.unsupported;
      last_out    <= side2.last;
    end
  end

  pf2r_decode u_decode (
    .clk          (clk),
    .en           (en1),
    .pixel_format (pixel_format),
    .raw_pixel    (raw_pixel),
    .last_in      (last_in),
    .ops          (ops),
    .side         (side1)
  );

  for (genvar i = 0; i < NumChan; i++) begin : g_chan
    pf2r_mult u_mult (
      .clk  (clk),
      .en   (en2),
      .op   (ops[i]),
      .prod (prods[i])
    );

    pf2r_finish u_finish (
      .clk  (clk),
      .en   (en3),
      .prod (prods[i]),
      .chan (chans[i])
    );
  end

  assign red   = chans[0];
  assign green = chans[1];
  assign blue  = chans[2];
  assign alpha = chans[3];

endmodule
`default_nettype wire

// ===== hw/rtl/pf2r_checker.sv =====
`default_nettype none
`include "pixel_format_to_rgba8_top_assert.svh"
module pf2r_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [pf2r_pkg::ChanW-1:0]    red,
  input wire logic [pf2r_pkg::ChanW-1:0]    green,
  input wire logic [pf2r_pkg::ChanW-1:0]    blue,
  input wire logic [pf2r_pkg::ChanW-1:0]    alpha,
  input wire logic                          unsupported,
  input wire logic                          last_out
);
  import pf2r_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // An unsupported format never leaks channel data.
  `PF2R_ASSERT_IMPLY(a_unsupported_zero, clk, rst, out_valid && unsupported,
    red == '0 && green == '0 && blue == '0 && alpha == '0)

  // With the output draining, an accepted request passes the decode, multiply and finish registers to out_valid.
  `PF2R_ASSERT_IMPLY(a_latency, clk, rst,
    $past(in_acc, 3) && !$past(out_stall, 1) && !$past(out_stall, 2)
      && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3),
    out_valid)

  `PF2R_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  `PF2R_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall,
    $stable(red) && $stable(green) && $stable(blue) && $stable(alpha)
      && $stable(unsupported) && $stable(last_out))

endmodule

bind pixel_format_to_rgba8_top pf2r_checker u_checker (.*);
`default_nettype wire
